// File: sv/apfp_pkg.sv
package apfp_pkg;

    // Frame geometry and store sizing
    localparam int MAX_DIM      = 2048;
    localparam int DIM_W        = $clog2(MAX_DIM);
    localparam int CFG_W        = DIM_W + 1;
    localparam int PACKED_BYTES = 8192;
    localparam int IDX_W        = $clog2(PACKED_BYTES);
    localparam int PROD_W       = DIM_W + CFG_W;
    localparam int ADDR_W       = 24;
    localparam int PIX_W        = 24;

    localparam logic [15:0] MONO_THRESHOLD = 16'h8FFF;
    localparam logic [1:0]  GREY_MASK      = 2'h3;

    // Reset values of the configuration registers
    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = CFG_W'(320);
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = CFG_W'(240);

    typedef enum logic [1:0] {
        FMT_MONO   = 2'd0,
        FMT_GREY   = 2'd1,
        FMT_RGB565 = 2'd2,
        FMT_RGB888 = 2'd3
    } fmt_t;

    typedef enum logic [1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_PIXEL_FORMAT = 2'd2
    } reg_idx_t;

    typedef enum logic {
        OP_SET_AREA = 1'b0,
        OP_PIXEL    = 1'b1
    } opcode_t;

    // Request after position lookup and row multiply
    typedef struct packed {
        logic              pixel;
        logic [DIM_W-1:0]  x;
        logic [DIM_W-1:0]  y;
        logic [PROD_W-1:0] prod;
        logic [PIX_W-1:0]  pix;
        logic              done;
    } stage_a_t;

    // Request after address and bounds resolution
    typedef struct packed {
        logic              packed_wr;
        logic              write_valid;
        logic              out_of_frame;
        logic [ADDR_W-1:0] byte_address;
        logic [PIX_W-1:0]  write_data;
        logic [1:0]        byte_count;
        logic [7:0]        bit_mask;
        logic [7:0]        bit_set;
        logic              done;
    } stage_b_t;

endpackage

// File: sv/apfp_ifs.sv
interface apfp_item_if;
    import apfp_pkg::*;
    logic               valid;
    logic               ready;
    logic               opcode;
    logic [DIM_W-1:0]   area_x_first;
    logic [DIM_W-1:0]   area_y_first;
    logic [DIM_W-1:0]   area_x_last;
    logic [DIM_W-1:0]   area_y_last;
    logic [PIX_W-1:0]   pixel_value;

    modport source (output valid, opcode, area_x_first, area_y_first, area_x_last,
                    area_y_last, pixel_value, input ready);
    modport sink   (input valid, opcode, area_x_first, area_y_first, area_x_last,
                    area_y_last, pixel_value, output ready);
endinterface

interface apfp_result_if;
    import apfp_pkg::*;
    logic               valid;
    logic               ready;
    logic               write_valid;
    logic               out_of_frame;
    logic [ADDR_W-1:0]  byte_address;
    logic [PIX_W-1:0]   write_data;
    logic [1:0]         byte_count;
    logic               area_done;

    modport source (output valid, write_valid, out_of_frame, byte_address, write_data,
                    byte_count, area_done, input ready);
    modport sink   (input valid, write_valid, out_of_frame, byte_address, write_data,
                    byte_count, area_done, output ready);
endinterface

interface apfp_cfg_if;
    import apfp_pkg::*;
    logic               valid;
    logic               ready;
    logic [1:0]         index;
    logic [CFG_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: sv/apfp_front.sv
module apfp_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       adv,
    input  logic                       accept,
    input  logic                       opcode,
    input  logic [apfp_pkg::DIM_W-1:0] area_x_first,
    input  logic [apfp_pkg::DIM_W-1:0] area_y_first,
    input  logic [apfp_pkg::DIM_W-1:0] area_x_last,
    input  logic [apfp_pkg::DIM_W-1:0] area_y_last,
    input  logic [apfp_pkg::PIX_W-1:0] pixel_value,
    input  apfp_pkg::fmt_t             fmt,
    input  logic [apfp_pkg::CFG_W-1:0] frame_width,
    output logic                       a_valid,
    output apfp_pkg::stage_a_t         a
);
    import apfp_pkg::*;

    logic [DIM_W-1:0]  column_now_reg, column_now_next;
    logic [DIM_W-1:0]  row_now_reg, row_now_next;
    logic [DIM_W-1:0]  rect_left_reg, rect_left_next;
    logic [DIM_W-1:0]  rect_right_reg, rect_right_next;
    logic [DIM_W-1:0]  rect_bottom_reg, rect_bottom_next;
    logic              a_valid_reg;
    stage_a_t          a_reg, a_next;
    logic [CFG_W-1:0]  mul_op;
    logic [PROD_W-1:0] prod;

    // Pick the row stride for the active format
    always_comb
    begin
        unique case (fmt)
            FMT_MONO: mul_op = CFG_W'(frame_width[CFG_W-1:3]);
            FMT_GREY: mul_op = CFG_W'(frame_width[CFG_W-1:2]);
            default:  mul_op = frame_width;
        endcase
    end

    assign prod = PROD_W'(row_now_reg) * PROD_W'(mul_op);

    // Advance the position or load a new rectangle
    always_comb
    begin
        column_now_next  = column_now_reg;
        row_now_next     = row_now_reg;
        rect_left_next   = rect_left_reg;
        rect_right_next  = rect_right_reg;
        rect_bottom_next = rect_bottom_reg;
        if (accept)
        begin
            if (opcode == OP_SET_AREA)
            begin
                rect_left_next   = area_x_first;
                row_now_next     = area_y_first;
                rect_right_next  = area_x_last;
                rect_bottom_next = area_y_last;
                column_now_next  = area_x_first;
            end
            else if (column_now_reg == rect_right_reg)
            begin
                column_now_next = rect_left_reg;
                row_now_next    = row_now_reg + DIM_W'(1);
            end
            else
            begin
                column_now_next = column_now_reg + DIM_W'(1);
            end
        end
    end

    // Capture the request with its position
    always_comb
    begin
        a_next.pixel = (opcode == OP_PIXEL);
        a_next.x     = column_now_reg;
        a_next.y     = row_now_reg;
        a_next.prod  = prod;
        a_next.pix   = pixel_value;
        a_next.done  = (opcode == OP_PIXEL) && (column_now_reg == rect_right_reg)
                       && (row_now_reg == rect_bottom_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_now_reg  <= '0;
            row_now_reg     <= '0;
            rect_left_reg   <= '0;
            rect_right_reg  <= '0;
            rect_bottom_reg <= '0;
            a_valid_reg     <= 1'b0;
        end
        else
        begin
            column_now_reg  <= column_now_next;
            row_now_reg     <= row_now_next;
            rect_left_reg   <= rect_left_next;
            rect_right_reg  <= rect_right_next;
            rect_bottom_reg <= rect_bottom_next;
            if (adv)
            begin
                a_valid_reg <= accept;
            end
        end
    end

    // Hold payload while stalled
    always_ff @(posedge clk)
    begin
        if (adv && accept)
        begin
            a_reg <= a_next;
        end
    end

    assign a_valid = a_valid_reg;
    assign a       = a_reg;

endmodule

// File: sv/apfp_addr.sv
module apfp_addr (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       adv,
    input  logic                       a_valid,
    input  apfp_pkg::stage_a_t         a,
    input  apfp_pkg::fmt_t             fmt,
    input  logic [apfp_pkg::CFG_W-1:0] frame_width,
    input  logic [apfp_pkg::CFG_W-1:0] frame_height,
    output logic [apfp_pkg::IDX_W-1:0] rd_addr,
    output logic                       b_valid,
    output apfp_pkg::stage_b_t         b
);
    import apfp_pkg::*;

    logic              x_over;
    logic              y_over;
    logic [8:0]        x_part;
    logic [ADDR_W-1:0] idx_full;
    logic              idx_over;
    logic [ADDR_W-1:0] lin;
    logic [ADDR_W-1:0] lin2;
    logic [7:0]        grey_sum;
    logic [1:0]        bits;
    logic [2:0]        shift;
    logic [7:0]        mask_base;
    logic              b_valid_reg;
    stage_b_t          b_reg, b_next;

    assign x_over = CFG_W'(a.x) >= frame_width;
    assign y_over = CFG_W'(a.y) >= frame_height;

    // Packed byte index
    assign x_part   = (fmt == FMT_MONO) ? 9'(a.x[DIM_W-1:3]) : 9'(a.x[DIM_W-1:2]);
    assign idx_full = ADDR_W'(a.prod) + ADDR_W'(x_part);
    assign idx_over = idx_full >= ADDR_W'(PACKED_BYTES);
    assign rd_addr  = idx_full[IDX_W-1:0];

    // Direct byte address, wrapped
    assign lin  = ADDR_W'(a.prod) + ADDR_W'(a.x);
    assign lin2 = {lin[ADDR_W-2:0], 1'b0};

    // Pixel bits and their lane in the byte
    assign grey_sum = 8'(a.pix[15:11]) + 8'({a.pix[10:5], 1'b0}) + 8'(a.pix[4:0]);

    always_comb
    begin
        if (fmt == FMT_MONO)
        begin
            bits      = (a.pix[15:0] > MONO_THRESHOLD) ? 2'b00 : 2'b01;
            shift     = a.x[2:0];
            mask_base = 8'h01;
        end
        else
        begin
            bits      = ~grey_sum[3:2] & GREY_MASK;
            shift     = {a.x[1:0], 1'b0};
            mask_base = 8'(GREY_MASK);
        end
    end

    // Resolve bounds and fields per format
    always_comb
    begin
        b_next = '0;
        b_next.done = a.done;
        if (a.pixel)
        begin
            unique case (fmt) inside
                FMT_MONO, FMT_GREY:
                begin
                    if (x_over || y_over || idx_over)
                    begin
                        b_next.out_of_frame = 1'b1;
                    end
                    else
                    begin
                        b_next.packed_wr    = 1'b1;
                        b_next.write_valid  = 1'b1;
                        b_next.byte_address = ADDR_W'(idx_full[IDX_W-1:0]);
                        b_next.byte_count   = 2'd1;
                        b_next.bit_mask     = mask_base << shift;
                        b_next.bit_set      = 8'(bits) << shift;
                    end
                end
                FMT_RGB565:
                begin
                    if (y_over)
                    begin
                        b_next.out_of_frame = 1'b1;
                    end
                    else
                    begin
                        b_next.write_valid  = 1'b1;
                        b_next.byte_address = lin2;
                        b_next.write_data   = PIX_W'(a.pix[15:0]);
                        b_next.byte_count   = 2'd2;
                    end
                end
                default:
                begin
                    if (y_over)
                    begin
                        b_next.out_of_frame = 1'b1;
                    end
                    else
                    begin
                        b_next.write_valid  = 1'b1;
                        b_next.byte_address = lin2 + lin;
                        b_next.write_data   = a.pix;
                        b_next.byte_count   = 2'd3;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            b_valid_reg <= a_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && a_valid)
        begin
            b_reg <= b_next;
        end
    end

    assign b_valid = b_valid_reg;
    assign b       = b_reg;

endmodule

// File: sv/apfp_store.sv
module apfp_store (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       rd_en,
    input  logic [apfp_pkg::IDX_W-1:0] rd_addr,
    input  logic                       wr_en,
    input  logic [apfp_pkg::IDX_W-1:0] wr_addr,
    input  logic [7:0]                 wr_data,
    output logic [7:0]                 old_byte,
    output logic                       clear_done
);
    import apfp_pkg::*;

    logic [7:0]       mem [PACKED_BYTES];
    logic [IDX_W:0]   clr_cnt_reg;
    logic             clearing;
    logic [7:0]       rd_data_reg;
    logic [IDX_W-1:0] rd_addr_reg;
    logic             last_valid_reg;
    logic [IDX_W-1:0] last_addr_reg;
    logic [7:0]       last_data_reg;

    assign clearing = !clr_cnt_reg[IDX_W];

    // Sweep the store to zero after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (clearing)
        begin
            clr_cnt_reg <= clr_cnt_reg + (IDX_W+1)'(1);
        end
    end

    // Single write port: clear sweep or pixel update
    always_ff @(posedge clk)
    begin
        if (clearing)
        begin
            mem[clr_cnt_reg[IDX_W-1:0]] <= 8'h00;
        end
        else if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read, held while the pipe stalls
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
            rd_addr_reg <= rd_addr;
        end
    end

    // Track the write that lands on the same edge as the read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_valid_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            last_valid_reg <= wr_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            last_addr_reg <= wr_addr;
            last_data_reg <= wr_data;
        end
    end

    // Forward the byte that the read missed
    assign old_byte = (last_valid_reg && (last_addr_reg == rd_addr_reg))
                      ? last_data_reg : rd_data_reg;
    assign clear_done = !clearing;

endmodule

// File: sv/area_pixel_framebuffer_packer.sv
// Area pixel framebuffer packer.
// Channels: item (sink) carries set-area and pixel requests, result (source)
// carries one result per request, cfg (sink) writes frame_width (index 0),
// frame_height (index 1) and pixel_format (index 2); cfg is always ready and
// must only be written while no request is in flight.
// Pipeline: position/multiply stage, address stage with store read, merge and
// output. Throughput: one request per cycle unless result is held or the store
// is clearing. The packed formats read, modify and write a single-port-write
// byte store; a pixel hitting the byte written on the same edge as its read
// takes the forwarded byte, so no bubble is needed.
// Reset: position, rectangle and configuration return to their defaults and the
// byte store is swept to zero, one byte per cycle over all 8192 bytes, during
// which item.ready stays low; cfg writes are taken throughout.
// Stall: while result is held, requests keep entering until the address stage
// holds one, then item.ready drops until the result is taken.
module area_pixel_framebuffer_packer (
    input  logic          clk,
    input  logic          rst_n,
    apfp_item_if.sink     item,
    apfp_result_if.source result,
    apfp_cfg_if.sink      cfg
);
    import apfp_pkg::*;

    logic [CFG_W-1:0] frame_width_reg;
    logic [CFG_W-1:0] frame_height_reg;
    fmt_t             pixel_format_reg;
    logic             adv;
    logic             accept;
    logic             clear_done;
    logic             a_valid;
    stage_a_t         a;
    logic [IDX_W-1:0] rd_addr;
    logic             b_valid;
    stage_b_t         b;
    logic [7:0]       old_byte;
    logic [7:0]       new_byte;
    logic             wr_en;
    logic             out_valid_reg;
    stage_b_t         out_reg, out_next;

    // Configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
            pixel_format_reg <= FMT_RGB565;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg.data;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg.data;
                REG_PIXEL_FORMAT: pixel_format_reg <= fmt_t'(cfg.data[1:0]);
                default:          ;
            endcase
        end
    end

    // Advance the pipe when the output register can drain or is empty, or the address stage is empty
    assign adv        = !b_valid || !out_valid_reg || result.ready;
    assign item.ready = adv && clear_done;
    assign accept     = item.valid && item.ready;

    apfp_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .accept       (accept),
        .opcode       (item.opcode),
        .area_x_first (item.area_x_first),
        .area_y_first (item.area_y_first),
        .area_x_last  (item.area_x_last),
        .area_y_last  (item.area_y_last),
        .pixel_value  (item.pixel_value),
        .fmt          (pixel_format_reg),
        .frame_width  (frame_width_reg),
        .a_valid      (a_valid),
        .a            (a)
    );

    apfp_addr u_addr (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .a_valid      (a_valid),
        .a            (a),
        .fmt          (pixel_format_reg),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .rd_addr      (rd_addr),
        .b_valid      (b_valid),
        .b            (b)
    );

    // Merge the pixel bits into the stored byte
    assign new_byte = (old_byte & ~b.bit_mask) | b.bit_set;
    assign wr_en    = adv && b_valid && b.packed_wr;

    apfp_store u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_en      (adv),
        .rd_addr    (rd_addr),
        .wr_en      (wr_en),
        .wr_addr    (b.byte_address[IDX_W-1:0]),
        .wr_data    (new_byte),
        .old_byte   (old_byte),
        .clear_done (clear_done)
    );

    always_comb
    begin
        out_next = b;
        if (b.packed_wr)
        begin
            out_next.write_data = PIX_W'(new_byte);
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv && b_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && b_valid)
        begin
            out_reg <= out_next;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.write_valid  = out_reg.write_valid;
    assign result.out_of_frame = out_reg.out_of_frame;
    assign result.byte_address = out_reg.byte_address;
    assign result.write_data   = out_reg.write_data;
    assign result.byte_count   = out_reg.byte_count;
    assign result.area_done    = out_reg.done;

endmodule

// File: test/tb_area_pixel_framebuffer_packer.sv
module tb_area_pixel_framebuffer_packer;
    import apfp_pkg::*;

    // One request on the item channel
    typedef struct packed {
        opcode_t           opcode;
        logic [DIM_W-1:0]  x_first;
        logic [DIM_W-1:0]  y_first;
        logic [DIM_W-1:0]  x_last;
        logic [DIM_W-1:0]  y_last;
        logic [PIX_W-1:0]  pixel_value;
    } area_req_t;

    // One framebuffer write report on the result channel
    typedef struct packed {
        logic              write_valid;
        logic              out_of_frame;
        logic [ADDR_W-1:0] byte_address;
        logic [PIX_W-1:0]  write_data;
        logic [1:0]        byte_count;
        logic              area_done;
    } fb_write_t;

    class fb_write_checker;
        logic [CFG_W-1:0] width_reg;
        logic [CFG_W-1:0] height_reg;
        fmt_t             format_reg;
        logic [DIM_W-1:0] cur_col;
        logic [DIM_W-1:0] cur_row;
        logic [DIM_W-1:0] left_col;
        logic [DIM_W-1:0] right_col;
        logic [DIM_W-1:0] bottom_row;
        logic [7:0]       store_copy [PACKED_BYTES];
        fb_write_t        pending_writes [$];
        int               errors;

        function new();
            width_reg  = FRAME_WIDTH_RST;
            height_reg = FRAME_HEIGHT_RST;
            format_reg = FMT_RGB565;
            cur_col    = '0;
            cur_row    = '0;
            left_col   = '0;
            right_col  = '0;
            bottom_row = '0;
            foreach (store_copy[i])
                store_copy[i] = 8'h00;
            errors = 0;
        endfunction

        function void set_register(reg_idx_t idx, logic [CFG_W-1:0] value);
            case (idx)
                REG_FRAME_WIDTH:  width_reg  = value;
                REG_FRAME_HEIGHT: height_reg = value;
                REG_PIXEL_FORMAT: format_reg = fmt_t'(value[1:0]);
                default: ;
            endcase
        endfunction

        // Work out the write report of one request and advance the position
        function fb_write_t predict_write(area_req_t req);
            fb_write_t   w;
            int unsigned x;
            int unsigned y;
            int unsigned idx;
            int unsigned sh;
            int unsigned luma;
            int unsigned bpp;
            logic [15:0] p16;
            logic [7:0]  mask;
            logic [7:0]  bits;
            logic [7:0]  nb;
            w = '0;
            if (req.opcode == OP_SET_AREA) begin
                left_col   = req.x_first;
                cur_row    = req.y_first;
                right_col  = req.x_last;
                bottom_row = req.y_last;
                cur_col    = req.x_first;
                return w;
            end
            x   = cur_col;
            y   = cur_row;
            p16 = req.pixel_value[15:0];
            w.area_done = (cur_col == right_col) && (cur_row == bottom_row);

            if (format_reg == FMT_MONO || format_reg == FMT_GREY) begin
                // Packed formats: bounds, byte index, then read-modify-write
                if (x >= width_reg || y >= height_reg) begin
                    w.out_of_frame = 1'b1;
                end else begin
                    if (format_reg == FMT_MONO) begin
                        idx  = y * (width_reg / 8) + x / 8;
                        sh   = x % 8;
                        mask = 8'h01;
                        bits = (p16 > MONO_THRESHOLD) ? 8'h00 : 8'h01;
                    end else begin
                        luma = p16[15:11] + 2 * p16[10:5] + p16[4:0];
                        idx  = y * (width_reg / 4) + x / 4;
                        sh   = (x % 4) * 2;
                        mask = {6'b0, GREY_MASK};
                        bits = 8'((~(luma >> 2)) & 32'(GREY_MASK));
                    end
                    if (idx >= PACKED_BYTES) begin
                        w.out_of_frame = 1'b1;
                    end else begin
                        nb = (store_copy[idx] & ~(mask << sh)) | (bits << sh);
                        store_copy[idx] = nb;
                        w.write_valid  = 1'b1;
                        w.byte_address = ADDR_W'(idx);
                        w.write_data   = PIX_W'(nb);
                        w.byte_count   = 2'd1;
                    end
                end
            end else begin
                // Direct formats: only the row is checked
                bpp = (format_reg == FMT_RGB565) ? 2 : 3;
                if (y >= height_reg) begin
                    w.out_of_frame = 1'b1;
                end else begin
                    w.write_valid  = 1'b1;
                    w.byte_address = ADDR_W'((y * width_reg + x) * bpp);
                    w.write_data   = (bpp == 2) ? PIX_W'(p16) : req.pixel_value;
                    w.byte_count   = 2'(bpp);
                end
            end

            // Advance along the row, wrap to the next row at the right edge
            if (cur_col == right_col) begin
                cur_col = left_col;
                cur_row = cur_row + 1'b1;
            end else begin
                cur_col = cur_col + 1'b1;
            end
            return w;
        endfunction

        function void note_request(area_req_t req);
            pending_writes.push_back(predict_write(req));
        endfunction

        function void compare_field(string name, logic [23:0] expv, logic [23:0] actv);
            if (expv !== actv) begin
                $error("%s: expected %0h, actual %0h", name, expv, actv);
                errors++;
            end
        endfunction

        function void check_write(fb_write_t got);
            fb_write_t want;
            if (pending_writes.size() == 0) begin
                $error("result with no request pending");
                errors++;
                return;
            end
            want = pending_writes.pop_front();
            compare_field("write_valid", 24'(want.write_valid), 24'(got.write_valid));
            compare_field("out_of_frame", 24'(want.out_of_frame), 24'(got.out_of_frame));
            compare_field("byte_address", want.byte_address, got.byte_address);
            compare_field("write_data", want.write_data, got.write_data);
            compare_field("byte_count", 24'(want.byte_count), 24'(got.byte_count));
            compare_field("area_done", 24'(want.area_done), 24'(got.area_done));
        endfunction

        function int pending_count();
            return pending_writes.size();
        endfunction
    endclass

    localparam int CLK_PERIOD = 20;

    logic clk;
    logic rst_n;
    bit   steady_stretch;
    int   cur_width;
    int   cur_height;
    fmt_t cur_format;

    fb_write_checker write_check;

    apfp_item_if   item_ch ();
    apfp_result_if result_ch ();
    apfp_cfg_if    cfg_ch ();

    area_pixel_framebuffer_packer i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    initial clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    // Watch all three channels and feed the scoreboard
    always @(posedge clk)
    begin : monitor
        area_req_t req;
        fb_write_t got;
        if (rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready)
                write_check.set_register(reg_idx_t'(cfg_ch.index), cfg_ch.data);
            if (item_ch.valid && item_ch.ready) begin
                req.opcode      = opcode_t'(item_ch.opcode);
                req.x_first     = item_ch.area_x_first;
                req.y_first     = item_ch.area_y_first;
                req.x_last      = item_ch.area_x_last;
                req.y_last      = item_ch.area_y_last;
                req.pixel_value = item_ch.pixel_value;
                write_check.note_request(req);
            end
            if (result_ch.valid && result_ch.ready) begin
                got.write_valid  = result_ch.write_valid;
                got.out_of_frame = result_ch.out_of_frame;
                got.byte_address = result_ch.byte_address;
                got.write_data   = result_ch.write_data;
                got.byte_count   = result_ch.byte_count;
                got.area_done    = result_ch.area_done;
                write_check.check_write(got);
            end
        end
    end

    // Result side: random stalls, plus one long hold-off to back up the pipe
    initial
    begin : result_sink
        int taken;
        int hold_left;
        bit held;
        taken     = 0;
        hold_left = 0;
        held      = 1'b0;
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (result_ch.valid && result_ch.ready)
                taken++;
            if (!held && taken >= 500) begin
                held      = 1'b1;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end else begin
                result_ch.ready <= steady_stretch || ($urandom_range(99) >= 25);
            end
        end
    end

    // Limit the run
    initial
    begin
        #(CLK_PERIOD * 600000);
        $display("DONE: errors detected");
        $finish;
    end

    function automatic area_req_t area_cmd(int xf, int yf, int xl, int yl);
        area_req_t req;
        req         = '0;
        req.opcode  = OP_SET_AREA;
        req.x_first = DIM_W'(xf);
        req.y_first = DIM_W'(yf);
        req.x_last  = DIM_W'(xl);
        req.y_last  = DIM_W'(yl);
        return req;
    endfunction

    function automatic area_req_t pixel_cmd(int unsigned value);
        area_req_t req;
        req             = '0;
        req.opcode      = OP_PIXEL;
        req.pixel_value = PIX_W'(value);
        return req;
    endfunction

    // Offer one request after a random gap, hold it until taken
    task automatic drive_request(area_req_t req);
        while ($urandom_range(99) < (steady_stretch ? 0 : 25)) begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid        <= 1'b1;
        item_ch.opcode       <= req.opcode;
        item_ch.area_x_first <= req.x_first;
        item_ch.area_y_first <= req.y_first;
        item_ch.area_x_last  <= req.x_last;
        item_ch.area_y_last  <= req.y_last;
        item_ch.pixel_value  <= req.pixel_value;
        do @(posedge clk); while (!item_ch.ready);
    endtask

    task automatic wait_for_drain();
        @(posedge clk);
        while (write_check.pending_count() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(reg_idx_t idx, int value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= CFG_W'(value);
        do @(posedge clk); while (!cfg_ch.ready);
    endtask

    // Stop requests, let the pipe empty, then set up a new frame
    task automatic apply_frame(int w, int h, fmt_t fmt);
        item_ch.valid <= 1'b0;
        wait_for_drain();
        write_register(REG_FRAME_WIDTH, w);
        write_register(REG_FRAME_HEIGHT, h);
        write_register(REG_PIXEL_FORMAT, int'(fmt));
        cfg_ch.valid <= 1'b0;
        cur_width  = w;
        cur_height = h;
        cur_format = fmt;
    endtask

    // Mostly small rectangles inside the frame, each followed by pixels that mostly fill it
    task automatic run_phase(int count);
        int sent;
        int npix;
        int xmax;
        int ymax;
        int bpr;
        int dx;
        int dy;
        logic [DIM_W-1:0] x0;
        logic [DIM_W-1:0] y0;
        logic [DIM_W-1:0] x1;
        logic [DIM_W-1:0] y1;
        logic [PIX_W-1:0] pix;
        sent = 0;
        xmax = (cur_width == 0) ? 0 : ((cur_width > MAX_DIM) ? MAX_DIM : cur_width) - 1;
        ymax = (cur_height == 0) ? 0 : ((cur_height > MAX_DIM) ? MAX_DIM : cur_height) - 1;
        bpr  = (cur_format == FMT_MONO) ? cur_width / 8 :
               (cur_format == FMT_GREY) ? cur_width / 4 : 0;
        // keep packed rows mostly within the byte store
        if (bpr > 0 && PACKED_BYTES / bpr <= ymax)
            ymax = PACKED_BYTES / bpr;
        while (sent < count) begin
            if ($urandom_range(99) < 10) begin
                x0   = DIM_W'($urandom);
                y0   = DIM_W'($urandom);
                x1   = DIM_W'($urandom);
                y1   = DIM_W'($urandom);
                npix = $urandom_range(0, 6);
            end else begin
                dx   = $urandom_range(0, 7);
                dy   = $urandom_range(0, 3);
                x0   = DIM_W'($urandom_range(0, xmax));
                y0   = DIM_W'($urandom_range(0, ymax));
                x1   = x0 + DIM_W'(dx);
                y1   = y0 + DIM_W'(dy);
                npix = (dx + 1) * (dy + 1);
                case ($urandom_range(9))
                    0: npix += $urandom_range(1, 5);
                    1: npix = $urandom_range(0, npix - 1);
                    default: ;
                endcase
            end
            drive_request(area_cmd(x0, y0, x1, y1));
            sent++;
            for (int k = 0; k < npix; k++) begin
                case ($urandom_range(3)) inside
                    0, 1: pix = PIX_W'($urandom);
                    2: pix = {8'($urandom), MONO_THRESHOLD - 16'd1 + 16'($urandom_range(0, 2))};
                    default: pix = $urandom_range(1) ? '1 : '0;
                endcase
                drive_request(pixel_cmd(pix));
                sent++;
            end
        end
    endtask

    initial
    begin : stimulus
        int w;
        int h;
        write_check = new();
        rst_n                = 1'b0;
        steady_stretch       = 1'b0;
        cur_width            = 320;
        cur_height           = 240;
        cur_format           = FMT_RGB565;
        item_ch.valid        <= 1'b0;
        item_ch.opcode       <= 1'b0;
        item_ch.area_x_first <= '0;
        item_ch.area_y_first <= '0;
        item_ch.area_x_last  <= '0;
        item_ch.area_y_last  <= '0;
        item_ch.pixel_value  <= '0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.index         <= '0;
        cfg_ch.data          <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Reset frame, rgb565: bottom-right corner, then one row past the frame
        drive_request(area_cmd(318, 238, 319, 239));
        drive_request(pixel_cmd(24'hFFFFFF));
        drive_request(pixel_cmd(24'h000000));
        drive_request(pixel_cmd(24'hA5F00F));
        drive_request(pixel_cmd(24'h5A0FF0));
        drive_request(pixel_cmd(24'h123456));
        // Largest coordinates: dropped row, then row wraps to zero, column unchecked
        drive_request(area_cmd(2047, 2047, 2047, 2047));
        drive_request(pixel_cmd(24'hC0FFEE));
        drive_request(pixel_cmd(24'h3C5A96));

        // Monochrome: threshold on both sides, crossing a byte boundary
        apply_frame(16, 4, FMT_MONO);
        drive_request(area_cmd(6, 0, 9, 0));
        drive_request(pixel_cmd(24'h008FFF));
        drive_request(pixel_cmd(24'h009000));
        drive_request(pixel_cmd(24'hFFFFFF));
        drive_request(pixel_cmd(24'hFF0000));
        drive_request(pixel_cmd(24'h00FFFF));
        // Empty rectangle: column runs past the frame edge
        drive_request(area_cmd(15, 3, 1, 3));
        drive_request(pixel_cmd(24'h000000));
        drive_request(pixel_cmd(24'h000000));

        // Two-bit grey: four pixels share one byte
        apply_frame(8, 2, FMT_GREY);
        drive_request(area_cmd(0, 0, 3, 0));
        drive_request(pixel_cmd(24'h000000));
        drive_request(pixel_cmd(24'h00FFFF));
        drive_request(pixel_cmd(24'h008410));
        drive_request(pixel_cmd(24'h002104));

        // Zero-size frame drops everything
        apply_frame(0, 0, FMT_RGB888);
        drive_request(area_cmd(0, 0, 0, 0));
        drive_request(pixel_cmd(24'h808080));

        // Random phases across frame settings
        for (int p = 0; p < 10; p++) begin
            case (p)
                0: apply_frame(2048, 2048, FMT_MONO);
                1: apply_frame(1, 1, FMT_GREY);
                2: apply_frame(2048, 1, FMT_RGB888);
                3: apply_frame(1, 2048, FMT_RGB565);
                4: apply_frame(40, 30, FMT_MONO);
                5: apply_frame(64, 48, FMT_GREY);
                6: apply_frame(4095, 4095, FMT_RGB888);
                7: apply_frame(0, 240, FMT_MONO);
                default:
                begin
                    w = $urandom_range(1) ? $urandom_range(1, 2048) : $urandom_range(1, 128);
                    h = $urandom_range(1) ? $urandom_range(1, 2048) : $urandom_range(1, 128);
                    apply_frame(w, h, fmt_t'($urandom_range(3)));
                end
            endcase
            steady_stretch = (p == 4);
            run_phase((p == 7) ? 40 : 190);
        end
        steady_stretch = 1'b0;

        // Drain with a bound, then report
        item_ch.valid <= 1'b0;
        @(posedge clk);
        for (int n = 0; n < 20000 && write_check.pending_count() != 0; n++)
            @(posedge clk);
        if (write_check.pending_count() != 0) begin
            $error("%0d results never arrived", write_check.pending_count());
            write_check.errors++;
        end
        repeat (4) @(posedge clk);
        if (write_check.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
